[sv/prpt_pkg.sv]
// ----------------------------------------------------------------------------
// prpt_pkg: shared types and constants of the peer RTT probe table
// Operation and result codes, controller states and control structs.
// ----------------------------------------------------------------------------
package prpt_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_PING   = 3'd1,
    OP_PONG   = 3'd2,
    OP_ADD    = 3'd3,
    OP_REMOVE = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_QUERY  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    RK_NONE  = 3'd0,
    RK_PROBE = 3'd1,
    RK_PONG  = 3'd2,
    RK_RTT   = 3'd3,
    RK_QUERY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

  localparam logic [1:0]  REG_ENABLE       = 2'd0;
  localparam logic [1:0]  REG_INTERVAL     = 2'd1;
  localparam logic [1:0]  REG_MISS_LIMIT   = 2'd2;
  localparam logic [15:0] RESET_INTERVAL   = 16'd2000;
  localparam logic [7:0]  RESET_MISS_LIMIT = 8'd5;
  localparam logic [13:0] RTT_CAP          = 14'd9999;
  localparam logic [7:0]  MISS_CAP         = 8'd255;
  localparam int          AVG_SHIFT        = 2;   // quarter weight, divide by 4

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the input item, reset the scan
    logic step;    // examine one table entry
    logic commit;  // write the table and the result register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;  // current entry is the last one needed
  } dp_stat_t;

endpackage

[sv/prpt_ctrl.sv]
// ----------------------------------------------------------------------------
// prpt_ctrl: sequencing state machine
// Takes one item, runs the table scan, commits, then holds the result.
// ----------------------------------------------------------------------------
module prpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output prpt_pkg::dp_cmd_t  cmd,
  input  prpt_pkg::dp_stat_t stat
);
  import prpt_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCAN;
      ST_SCAN:  if (stat.scan_done) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:  cmd.step = 1'b1;
      ST_WRITE: cmd.commit = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output open together");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SCAN)) else $error("accept did not start scan");

  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (out_valid && !cmd.commit)) else $error("commit not followed by result");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (state == ST_OUT)) else $error("result dropped");

endmodule

[sv/prpt_dp.sv]
// ----------------------------------------------------------------------------
// prpt_dp: peer table and scan datapath
// Holds the per-slot registers, config, scan trackers and result register.
// ----------------------------------------------------------------------------
module prpt_dp #(
  parameter int PEER_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  prpt_pkg::dp_cmd_t  cmd,
  output prpt_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         in_op,
  input  logic [31:0]        in_now,
  input  logic [31:0]        in_ip,
  input  logic [15:0]        in_port,
  input  logic [15:0]        in_seq,
  input  logic [31:0]        in_echo,
  input  logic [15:0]        in_key,
  output logic [2:0]         r_kind,
  output logic [3:0]         r_slot,
  output logic [31:0]        r_ip,
  output logic [15:0]        r_port,
  output logic [15:0]        r_seq,
  output logic [31:0]        r_time,
  output logic [13:0]        r_rtt,
  output logic [14:0]        r_avg,
  output logic               r_reach,
  output logic               r_found
);
  import prpt_pkg::*;

  localparam int IW = $clog2(PEER_SLOTS);
  localparam int CW = $clog2(PEER_SLOTS + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(PEER_SLOTS - 1);

  // Config
  logic        enable;
  logic [15:0] interval;
  logic [7:0]  miss_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      interval   <= RESET_INTERVAL;
      miss_limit <= RESET_MISS_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:     enable     <= cfg_data[0];
        REG_INTERVAL:   interval   <= cfg_data;
        REG_MISS_LIMIT: miss_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic [2:0]  op;
  logic [31:0] now, ip, echo;
  logic [15:0] port, seq, key;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_op;
      now  <= in_now;
      ip   <= in_ip;
      port <= in_port;
      seq  <= in_seq;
      echo <= in_echo;
      key  <= in_key;
    end
  end

  // Table
  logic [PEER_SLOTS-1:0] slot_active;
  logic [15:0] slot_key       [PEER_SLOTS];
  logic [31:0] slot_ip        [PEER_SLOTS];
  logic [15:0] slot_port      [PEER_SLOTS];
  logic [15:0] slot_next_seq  [PEER_SLOTS];
  logic [31:0] slot_last_send [PEER_SLOTS];
  logic [14:0] slot_avg_rtt   [PEER_SLOTS];
  logic [7:0]  slot_misses    [PEER_SLOTS];
  logic        slot_reached   [PEER_SLOTS];
  logic        slot_sent      [PEER_SLOTS];
  logic [CW-1:0] used_high_mark, round_robin_index;

  // Scan state
  logic [IW-1:0] scan_i;
  logic [CW-1:0] tries;
  logic          key_hit, ex_hit, ipm_hit, free_hit, tick_hit;
  logic [IW-1:0] key_idx, ex_idx, ipm_idx, free_idx, max_idx, tick_idx;
  logic [7:0]    max_mis;

  // Single read port
  logic [IW-1:0] rr_pos, scan_addr, sel_idx, rd_addr;
  logic          rd_act;
  logic [15:0]   rd_key, rd_port, rd_seq;
  logic [31:0]   rd_ip, rd_last;
  logic [14:0]   rd_avg;
  logic [7:0]    rd_mis;
  logic          rd_reached, rd_sent;

  always_comb begin
    rr_pos = (round_robin_index >= used_high_mark) ? '0 : round_robin_index[IW-1:0];
    scan_addr = (op == OP_TICK) ? rr_pos : scan_i;
    case (op)
      OP_TICK: sel_idx = tick_idx;
      OP_PONG: sel_idx = ex_hit ? ex_idx : ipm_idx;
      OP_ADD:  sel_idx = key_hit ? key_idx : (free_hit ? free_idx : max_idx);
      default: sel_idx = key_idx;
    endcase
    rd_addr    = cmd.commit ? sel_idx : scan_addr;
    rd_act     = slot_active[rd_addr];
    rd_key     = slot_key[rd_addr];
    rd_ip      = slot_ip[rd_addr];
    rd_port    = slot_port[rd_addr];
    rd_seq     = slot_next_seq[rd_addr];
    rd_last    = slot_last_send[rd_addr];
    rd_avg     = slot_avg_rtt[rd_addr];
    rd_mis     = slot_misses[rd_addr];
    rd_reached = slot_reached[rd_addr];
    rd_sent    = slot_sent[rd_addr];
  end

  // Scan control
  logic        need_scan, is_tick, due;
  logic [31:0] since;

  always_comb begin
    is_tick = (op == OP_TICK);
    case (op)
      OP_TICK:                      need_scan = enable && (used_high_mark != '0);
      OP_PONG:                      need_scan = enable;
      OP_ADD, OP_REMOVE, OP_QUERY:  need_scan = 1'b1;
      default:                      need_scan = 1'b0;
    endcase
    since = now - rd_last;
    due   = rd_act && (!rd_sent || since >= {16'd0, interval});
    if (!need_scan) begin
      stat.scan_done = 1'b1;
    end else if (is_tick) begin
      stat.scan_done = due || (tries == used_high_mark - CW'(1));
    end else begin
      stat.scan_done = (scan_i == LAST_SLOT);
    end
  end

  // Advance scan and track matches
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_i   <= '0;
      tries    <= '0;
      key_hit  <= 1'b0;
      ex_hit   <= 1'b0;
      ipm_hit  <= 1'b0;
      free_hit <= 1'b0;
      tick_hit <= 1'b0;
      key_idx  <= '0;
      ex_idx   <= '0;
      ipm_idx  <= '0;
      free_idx <= '0;
      max_idx  <= '0;
      tick_idx <= '0;
      max_mis  <= '0;
    end else if (cmd.step && need_scan) begin
      if (is_tick) begin
        tries <= tries + CW'(1);
        if (due) begin
          tick_hit <= 1'b1;
          tick_idx <= rr_pos;
        end
      end else begin
        scan_i <= scan_i + IW'(1);
        if (rd_act && rd_key == key && !key_hit) begin
          key_hit <= 1'b1;
          key_idx <= scan_i;
        end
        if (rd_act && rd_ip == ip && rd_port == port && !ex_hit) begin
          ex_hit <= 1'b1;
          ex_idx <= scan_i;
        end
        if (rd_act && rd_ip == ip && !ipm_hit) begin
          ipm_hit <= 1'b1;
          ipm_idx <= scan_i;
        end
        if (!rd_act && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= scan_i;
        end
        if (scan_i == '0 || rd_mis > max_mis) begin
          max_idx <= scan_i;
          max_mis <= rd_mis;
        end
      end
    end
  end

  // Pong sample and average
  logic [31:0] delta;
  logic [13:0] rtt;
  logic [16:0] avg_sum;
  logic [14:0] avg_new;

  always_comb begin
    delta = now - echo;
    if (delta[31]) begin
      rtt = '0;
    end else if (delta > {18'd0, RTT_CAP}) begin
      rtt = RTT_CAP;
    end else begin
      rtt = delta[13:0];
    end
    avg_sum = 17'(rtt) + 17'(rd_avg) + 17'({rd_avg, 1'b0});
    avg_new = rd_avg[14] ? {1'b0, rtt} : 15'(avg_sum >> AVG_SHIFT);
  end

  // Commit decisions
  logic do_probe, do_pong, do_add_new, do_add_upd, do_remove, do_clear;

  always_comb begin
    do_probe   = cmd.commit && is_tick && enable && tick_hit;
    do_pong    = cmd.commit && op == OP_PONG && enable && (ex_hit || ipm_hit);
    do_add_upd = cmd.commit && op == OP_ADD && key_hit;
    do_add_new = cmd.commit && op == OP_ADD && !key_hit;
    do_remove  = cmd.commit && op == OP_REMOVE && key_hit;
    do_clear   = cmd.commit && op == OP_CLEAR;
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (do_probe) begin
      slot_next_seq[sel_idx]  <= rd_seq + 16'd1;
      slot_last_send[sel_idx] <= now;
      slot_sent[sel_idx]      <= 1'b1;
      if (rd_mis != MISS_CAP) slot_misses[sel_idx] <= rd_mis + 8'd1;
    end
    if (do_pong) begin
      slot_misses[sel_idx]  <= '0;
      slot_reached[sel_idx] <= 1'b1;
      slot_avg_rtt[sel_idx] <= avg_new;
    end
    if (do_add_upd || do_add_new) begin
      slot_ip[sel_idx]   <= ip;
      slot_port[sel_idx] <= port;
    end
    if (do_add_new) begin
      slot_key[sel_idx]       <= key;
      slot_next_seq[sel_idx]  <= '0;
      slot_last_send[sel_idx] <= '0;
      slot_sent[sel_idx]      <= 1'b0;
      slot_avg_rtt[sel_idx]   <= '1;
      slot_misses[sel_idx]    <= '0;
      slot_reached[sel_idx]   <= 1'b0;
    end
  end

  // Control state of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active       <= '0;
      used_high_mark    <= '0;
      round_robin_index <= '0;
    end else begin
      if (cmd.step && need_scan && is_tick) begin
        round_robin_index <= CW'(rr_pos) + CW'(1);
      end
      if (do_add_new) begin
        slot_active[sel_idx] <= 1'b1;
        if (CW'(sel_idx) >= used_high_mark) used_high_mark <= CW'(sel_idx) + CW'(1);
      end
      if (do_remove) slot_active[sel_idx] <= 1'b0;
      if (do_clear) begin
        slot_active       <= '0;
        used_high_mark    <= '0;
        round_robin_index <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      r_kind  <= RK_NONE;
      r_slot  <= '0;
      r_ip    <= '0;
      r_port  <= '0;
      r_seq   <= '0;
      r_time  <= '0;
      r_rtt   <= '0;
      r_avg   <= '1;
      r_reach <= 1'b0;
      r_found <= 1'b0;
      case (op)
        OP_TICK: if (do_probe) begin
          r_kind <= RK_PROBE;
          r_slot <= 4'(sel_idx);
          r_ip   <= rd_ip;
          r_port <= rd_port;
          r_seq  <= rd_seq;
          r_time <= now;
        end
        OP_PING: if (enable) begin
          r_kind <= RK_PONG;
          r_ip   <= ip;
          r_port <= port;
          r_seq  <= seq;
          r_time <= echo;
        end
        OP_PONG: if (enable) begin
          r_kind <= RK_RTT;
          r_rtt  <= rtt;
          if (do_pong) begin
            r_slot  <= 4'(sel_idx);
            r_avg   <= avg_new;
            r_reach <= (miss_limit != '0);
            r_found <= 1'b1;
          end
        end
        OP_ADD: begin
          r_slot  <= 4'(sel_idx);
          r_found <= key_hit;
        end
        OP_REMOVE: if (key_hit) begin
          r_slot  <= 4'(sel_idx);
          r_found <= 1'b1;
        end
        OP_QUERY: begin
          r_kind <= RK_QUERY;
          if (key_hit) begin
            r_slot  <= 4'(sel_idx);
            r_avg   <= rd_avg;
            r_reach <= rd_reached && (rd_mis < miss_limit);
            r_found <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/peer_rtt_probe_table.sv]
// ----------------------------------------------------------------------------
// peer_rtt_probe_table: peer table with periodic probes and smoothed RTT
// Probes due peers round-robin, echoes pings, averages pong round trips.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | one operation item (tuser = operation)
//  m_axis   | out       | one result item per input item (tuser = result_kind)
//  cfg      | in        | register writes, no read-back
//
//  An item is accepted, then scanned, committed and sent out.
//  Key and address scans read one slot per cycle over all PEER_SLOTS slots.
//  A tick scans 1..used slots round-robin and stops at the first due peer.
//  Ping, clear and disabled operations examine no slot. Reset clears the
//  active bits, counters and enable, and restores interval and miss limit.
//  A stalled result holds the block; no new item is taken until it leaves.
// ----------------------------------------------------------------------------
module peer_rtt_probe_table #(
  parameter int PEER_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // now_ms[31:0], peer_ip[63:32], peer_port[79:64], probe_seq[95:80],
  // echo_time[127:96], peer_key[143:128]
  input  logic [143:0] s_tdata,
  // operation[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slot[3:0], dest_ip[35:4], dest_port[51:36], out_seq[67:52],
  // out_time[99:68], rtt_sample[113:100], rtt_avg[128:114],
  // reachable[129], found[130], zero[135:131]
  output logic [135:0] m_tdata,
  // result_kind[2:0]
  output logic [2:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import prpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [3:0]  r_slot;
  logic [31:0] r_ip, r_time;
  logic [15:0] r_port, r_seq;
  logic [13:0] r_rtt;
  logic [14:0] r_avg;
  logic        r_reach, r_found;

  prpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  prpt_dp #(.PEER_SLOTS(PEER_SLOTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_tuser),
    .in_now    (s_tdata[31:0]),
    .in_ip     (s_tdata[63:32]),
    .in_port   (s_tdata[79:64]),
    .in_seq    (s_tdata[95:80]),
    .in_echo   (s_tdata[127:96]),
    .in_key    (s_tdata[143:128]),
    .r_kind    (m_tuser),
    .r_slot    (r_slot),
    .r_ip      (r_ip),
    .r_port    (r_port),
    .r_seq     (r_seq),
    .r_time    (r_time),
    .r_rtt     (r_rtt),
    .r_avg     (r_avg),
    .r_reach   (r_reach),
    .r_found   (r_found)
  );

  // Pack the result fields
  assign m_tdata = {5'd0, r_found, r_reach, r_avg, r_rtt, r_time, r_seq, r_port, r_ip, r_slot};

endmodule

[verif/peer_rtt_probe_table_tb.sv]
// ----------------------------------------------------------------------------
// peer_rtt_probe_table_tb: self-checking bench for the peer RTT probe table
// Streams operation items into the table under random idling on both sides,
// predicts every result item from a local copy of the peer table and checks
// each one in order, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_rtt_probe_table_tb;
  import prpt_pkg::*;

  localparam int          SLOTS      = 16;
  localparam logic [2:0]  OP_UNUSED  = 3'd7;
  localparam int          IDLE_PCT   = 22;
  localparam int          STALL_LIM  = 20000;
  localparam int          DRAIN_CYC  = 25;

  // one operation item, packed as on s_tdata / s_tuser
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] echo;
    logic [15:0] seq;
    logic [15:0] port;
    logic [31:0] ip;
    logic [31:0] now;
  } op_data_t;

  typedef struct {
    logic [2:0] op;
    op_data_t   d;
  } op_item_t;

  // one result item, packed as on m_tdata, plus the kind from m_tuser
  typedef struct packed {
    logic [4:0]         pad;
    logic               found;
    logic               reach;
    logic signed [14:0] avg;
    logic [13:0]        rtt;
    logic [31:0]        tm;
    logic [15:0]        seq;
    logic [15:0]        port;
    logic [31:0]        ip;
    logic [3:0]         slot;
  } res_data_t;

  typedef struct {
    logic [2:0] kind;
    res_data_t  d;
  } res_item_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  peer_rtt_probe_table u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // table shadow used for prediction
  logic        tbl_on;
  logic [15:0] tbl_interval;
  logic [7:0]  tbl_limit;
  logic        pr_active [SLOTS];
  logic [15:0] pr_key    [SLOTS];
  logic [31:0] pr_ip     [SLOTS];
  logic [15:0] pr_port   [SLOTS];
  logic [15:0] pr_seq    [SLOTS];
  logic [31:0] pr_last   [SLOTS];
  int          pr_avg    [SLOTS];
  logic [7:0]  pr_miss   [SLOTS];
  logic        pr_reached[SLOTS];
  logic        pr_sent   [SLOTS];
  int          high_mark;
  int          rr_idx;

  op_item_t  pending_ops[$];
  res_item_t expected_res[$];
  int        sent_cnt, got_cnt, err_cnt, kind_cnt[8];
  int        quiet_cycles;
  logic      hold_done;
  int        hold_cnt;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_key(logic [15:0] k);
    for (int i = 0; i < high_mark; i++)
      if (pr_active[i] && pr_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int match_addr(logic [31:0] ip, logic [15:0] port);
    for (int i = 0; i < high_mark; i++)
      if (pr_active[i] && pr_ip[i] == ip && pr_port[i] == port) return i;
    for (int i = 0; i < high_mark; i++)
      if (pr_active[i] && pr_ip[i] == ip) return i;
    return -1;
  endfunction

  // advance the table shadow by one item and return the result it causes
  function automatic res_item_t table_step(op_item_t it);
    res_item_t r;
    int s;
    int p;
    logic [31:0] dt;
    logic [13:0] rtt;
    r.kind = RK_NONE;
    r.d = '0;
    r.d.avg = -15'sd1;
    if (it.op == OP_TICK && tbl_on) begin
      for (int t = 0; t < high_mark; t++) begin
        if (rr_idx >= high_mark) rr_idx = 0;
        p = rr_idx;
        rr_idx++;
        if (!pr_active[p]) continue;
        if (!pr_sent[p] || (it.d.now - pr_last[p]) >= {16'd0, tbl_interval}) begin
          r.kind = RK_PROBE;
          r.d.slot = p[3:0];
          r.d.ip = pr_ip[p];
          r.d.port = pr_port[p];
          r.d.seq = pr_seq[p];
          r.d.tm = it.d.now;
          pr_seq[p] = pr_seq[p] + 16'd1;
          pr_last[p] = it.d.now;
          pr_sent[p] = 1'b1;
          if (pr_miss[p] != 8'hFF) pr_miss[p] = pr_miss[p] + 8'd1;
          break;
        end
      end
    end else if (it.op == OP_PING && tbl_on) begin
      r.kind = RK_PONG;
      r.d.ip = it.d.ip;
      r.d.port = it.d.port;
      r.d.seq = it.d.seq;
      r.d.tm = it.d.echo;
    end else if (it.op == OP_PONG && tbl_on) begin
      dt = it.d.now - it.d.echo;
      if (dt[31]) rtt = '0;
      else if (dt > 32'd9999) rtt = 14'd9999;
      else rtt = dt[13:0];
      r.kind = RK_RTT;
      r.d.rtt = rtt;
      s = match_addr(it.d.ip, it.d.port);
      if (s >= 0) begin
        pr_miss[s] = '0;
        pr_reached[s] = 1'b1;
        if (pr_avg[s] < 0) pr_avg[s] = rtt;
        else pr_avg[s] = (int'(rtt) + 3 * pr_avg[s]) / 4;
        r.d.slot = s[3:0];
        r.d.avg = pr_avg[s][14:0];
        r.d.reach = pr_reached[s] && pr_miss[s] < tbl_limit;
        r.d.found = 1'b1;
      end
    end else if (it.op == OP_ADD) begin
      s = find_key(it.d.key);
      if (s >= 0) begin
        pr_ip[s] = it.d.ip;
        pr_port[s] = it.d.port;
        r.d.found = 1'b1;
      end else begin
        s = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!pr_active[i]) begin
            s = i;
            break;
          end
        // full table: evict the lowest slot with the most misses
        if (s < 0) begin
          s = 0;
          for (int i = 1; i < SLOTS; i++)
            if (pr_miss[i] > pr_miss[s]) s = i;
        end
        pr_active[s] = 1'b1;
        pr_key[s] = it.d.key;
        pr_ip[s] = it.d.ip;
        pr_port[s] = it.d.port;
        pr_seq[s] = '0;
        pr_last[s] = '0;
        pr_sent[s] = 1'b0;
        pr_avg[s] = -1;
        pr_miss[s] = '0;
        pr_reached[s] = 1'b0;
        if (s >= high_mark) high_mark = s + 1;
      end
      r.d.slot = s[3:0];
    end else if (it.op == OP_REMOVE) begin
      s = find_key(it.d.key);
      if (s >= 0) begin
        pr_active[s] = 1'b0;
        r.d.slot = s[3:0];
        r.d.found = 1'b1;
      end
    end else if (it.op == OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) pr_active[i] = 1'b0;
      high_mark = 0;
      rr_idx = 0;
    end else if (it.op == OP_QUERY) begin
      r.kind = RK_QUERY;
      s = find_key(it.d.key);
      if (s >= 0) begin
        r.d.slot = s[3:0];
        r.d.avg = pr_avg[s][14:0];
        r.d.reach = pr_reached[s] && pr_miss[s] < tbl_limit;
        r.d.found = 1'b1;
      end
    end
    return r;
  endfunction

  // sender: offer the next pending item, idling at random outside the calm stretch
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        op_item_t acc;
        acc.op = s_tuser;
        acc.d = s_tdata;
        expected_res.push_back(table_step(acc));
        sent_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() > 0 &&
            ((sent_cnt >= 600 && sent_cnt < 800) || $urandom_range(99) >= IDLE_PCT)) begin
          op_item_t nx;
          nx = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nx.op;
          s_tdata <= nx.d;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result item, stall at random, hold off once for long
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        res_item_t got, want;
        got.kind = m_tuser;
        got.d = m_tdata;
        got_cnt++;
        kind_cnt[m_tuser]++;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result kind %0d data %h", $time, m_tuser, m_tdata);
          err_cnt++;
        end else begin
          want = expected_res.pop_front();
          if (got.kind !== want.kind || got.d !== want.d) begin
            $display("%0t: mismatch kind exp %0d got %0d | slot %0d/%0d ip %h/%h port %h/%h",
                     $time, want.kind, got.kind, want.d.slot, got.d.slot,
                     want.d.ip, got.d.ip, want.d.port, got.d.port);
            $display("  seq %h/%h time %h/%h rtt %0d/%0d avg %0d/%0d reach %b/%b found %b/%b",
                     want.d.seq, got.d.seq, want.d.tm, got.d.tm, want.d.rtt, got.d.rtt,
                     want.d.avg, got.d.avg, want.d.reach, got.d.reach,
                     want.d.found, got.d.found);
            err_cnt++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else if (!hold_done && got_cnt >= 300) begin
        hold_done <= 1'b1;
        hold_cnt <= 500;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (got_cnt >= 600 && got_cnt < 800) || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIM) begin
        $display("%0t: timeout, %0d items sent, %0d results", $time, sent_cnt, got_cnt);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_ENABLE) tbl_on = val[0];
    else if (idx == REG_INTERVAL) tbl_interval = val;
    else if (idx == REG_MISS_LIMIT) tbl_limit = val[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_table(logic on, logic [15:0] ivl, logic [7:0] lim);
    write_reg(REG_ENABLE, {15'd0, on});
    write_reg(REG_INTERVAL, ivl);
    write_reg(REG_MISS_LIMIT, {8'd0, lim});
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0 && !s_tvalid && expected_res.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic push_op(logic [2:0] op, logic [31:0] now, logic [31:0] ip,
                         logic [15:0] port, logic [15:0] seq, logic [31:0] echo,
                         logic [15:0] key);
    op_item_t it;
    it.op = op;
    it.d = '{key: key, echo: echo, seq: seq, port: port, ip: ip, now: now};
    pending_ops.push_back(it);
  endtask

  // random item: small address and key pools so pongs and keys match often
  task automatic push_random();
    logic [2:0]  op;
    logic [31:0] ip, echo;
    logic [15:0] port, key;
    int w;
    w = $urandom_range(99);
    if (w < 30) op = OP_TICK;
    else if (w < 40) op = OP_PING;
    else if (w < 64) op = OP_PONG;
    else if (w < 80) op = OP_ADD;
    else if (w < 86) op = OP_REMOVE;
    else if (w < 88) op = OP_CLEAR;
    else if (w < 98) op = OP_QUERY;
    else op = OP_UNUSED;
    if ($urandom_range(9) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 1500);
    ip = ($urandom_range(9) == 0) ? $urandom : 32'h0A00_0000 + $urandom_range(0, 5);
    port = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(5000 + $urandom_range(0, 2));
    key = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
    w = $urandom_range(9);
    if (w == 0) echo = $urandom;
    else if (w == 1) echo = clock_ms + $urandom_range(1, 500);
    else echo = clock_ms - $urandom_range(0, 12000);
    push_op(op, clock_ms, ip, port, 16'($urandom), echo, key);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent_cnt = 0;
    got_cnt = 0;
    err_cnt = 0;
    quiet_cycles = 0;
    hold_done = 1'b0;
    hold_cnt = 0;
    clock_ms = 32'd1000;
    foreach (kind_cnt[i]) kind_cnt[i] = 0;
    tbl_on = 1'b0;
    tbl_interval = RESET_INTERVAL;
    tbl_limit = RESET_MISS_LIMIT;
    for (int i = 0; i < SLOTS; i++) begin
      pr_active[i] = 1'b0;
      pr_key[i] = '0;
      pr_ip[i] = '0;
      pr_port[i] = '0;
      pr_seq[i] = '0;
      pr_last[i] = '0;
      pr_avg[i] = 0;
      pr_miss[i] = '0;
      pr_reached[i] = 1'b0;
      pr_sent[i] = 1'b0;
    end
    high_mark = 0;
    rr_idx = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // disabled table: tick, ping and pong answer nothing
    push_op(OP_ADD, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd0, 16'hFFFF);
    push_op(OP_TICK, 32'd5, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    push_op(OP_PING, 32'd5, 32'h1234_5678, 16'h0101, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
    push_op(OP_PONG, 32'd9, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd0, 16'd0);
    drain();
    set_table(1'b1, RESET_INTERVAL, RESET_MISS_LIMIT);

    // directed: extremes, every operation, address fallback, clamps
    push_op(OP_ADD, 32'd0, 32'h0000_0000, 16'h0000, 16'd0, 32'd0, 16'h0000);
    push_op(OP_ADD, 32'd0, 32'hC0A8_0001, 16'd80, 16'd0, 32'd0, 16'h0001);
    push_op(OP_ADD, 32'd0, 32'hC0A8_0002, 16'd81, 16'd0, 32'd0, 16'h0001);
    push_op(OP_TICK, 32'hFFFF_FFF0, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    push_op(OP_TICK, 32'hFFFF_FFF1, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    push_op(OP_TICK, 32'hFFFF_FFF2, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    push_op(OP_TICK, 32'd2000, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    push_op(OP_PING, 32'd0, 32'h0, 16'h0, 16'h0, 32'h0, 16'h0);
    push_op(OP_PONG, 32'd100, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd40, 16'd0);
    push_op(OP_PONG, 32'd100, 32'hC0A8_0002, 16'd999, 16'd0, 32'd200, 16'd0);
    push_op(OP_PONG, 32'd20000, 32'hC0A8_0002, 16'd81, 16'd0, 32'd0, 16'd0);
    push_op(OP_PONG, 32'h7FFF_FFFF, 32'h0, 16'h0, 16'd0, 32'hFFFF_FFFF, 16'd0);
    push_op(OP_PONG, 32'd300, 32'hDEAD_BEEF, 16'd1, 16'd0, 32'd290, 16'd0);
    push_op(OP_QUERY, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'h0001);
    push_op(OP_QUERY, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'hFFFF);
    push_op(OP_REMOVE, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'h0000);
    push_op(OP_REMOVE, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'h7777);
    push_op(OP_UNUSED, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'h0001);
    push_op(OP_CLEAR, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    push_op(OP_QUERY, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'h0001);
    push_op(OP_TICK, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 16'd0);
    drain();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_table(1'b1, RESET_INTERVAL, RESET_MISS_LIMIT);
        1: set_table(1'b1, 16'd0, 8'd0);
        2: set_table(1'b1, 16'hFFFF, 8'hFF);
        3: set_table(1'b1, 16'd1, 8'd1);
        4: set_table(1'b0, 16'd700, 8'd3);
        default: set_table(1'b1, 16'd300, 8'd3);
      endcase
      for (int n = 0; n < (ph == 4 ? 100 : 260); n++) push_random();
      drain();
    end

    $display("Checked %0d items: %0d probes, %0d pongs, %0d rtt updates, %0d queries",
             sent_cnt, kind_cnt[RK_PROBE], kind_cnt[RK_PONG], kind_cnt[RK_RTT],
             kind_cnt[RK_QUERY]);
    $display("Settings: default, zero interval and limit, maxima, minima, disabled");
    if (err_cnt == 0 && expected_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
